>>> rtl/rotation_matrix_to_euler_defines.svh
// assertion macros for the rotation matrix to euler angles block
// expects clk and rst_n to be visible where the macros are used
`ifndef ROTATION_MATRIX_TO_EULER_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// plain invariant checked on every clock edge outside reset
`define RME_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

>>> rtl/rme_pkg.sv
// shared constants and the cordic angle table for the euler angle block
// no dependencies
`default_nettype none

package rme_pkg;

  localparam int ENTRY_WIDTH_DEF = 16;
  localparam int THR_W           = 15;
  localparam int OUT_W           = 16;
  localparam int CORDIC_ITERS    = 30;
  localparam int PRESCALE_SH     = 24;
  localparam int ANG_W           = 34;
  localparam int ANG_FRAC        = 29;
  localparam int OUT_MAX         = 25736;
  localparam logic signed [ANG_W-1:0] PI_Q29 = 34'sd1686629713;
  localparam logic [THR_W-1:0] THR_RESET = 15'd1;

  // atan(2^-i) in q.29, rounded to nearest; small angles equal 2^(29-i)
  function automatic logic signed [ANG_W-1:0] atan_q29(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0: a = 34'sd421657428;
      1: a = 34'sd248918915;
      2: a = 34'sd131521918;
      3: a = 34'sd66762579;
      4: a = 34'sd33510843;
      5: a = 34'sd16771758;
      6: a = 34'sd8387925;
      7: a = 34'sd4194219;
      8: a = 34'sd2097141;
      9: a = 34'sd1048575;
      default: a = ANG_W'(64'sd1 <<< (ANG_FRAC - i));
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rotation_matrix_to_euler.sv
// Usage:
//   A matrix (seven q2.14 entries on in_r*) is transferred at a clock edge
//   with start high; busy is always low, so a new matrix may enter every
//   cycle. Each result appears on out_angle_x/y/z and out_singular for
//   exactly one cycle with out_valid high.
// Pipeline: a matrix passes the input register, the squares, their sum,
//   one stage per bit of the square root, an operand setup stage, 30 cordic
//   stages per angle lane and the rounding register.
// Throughput: one matrix per cycle; every stage advances each cycle.
// Configuration: cfg_singular_threshold is transferred when cfg_valid is high
//   (cfg_ready is always high); write it only while no matrix is in flight.
// Reset: rst_n low clears all stage valid bits and sets the threshold to 1.
// The receiver cannot stall: results are shown once and not held.
// depends on rme_pkg and rotation_matrix_to_euler_defines.svh
`default_nettype none
`include "rotation_matrix_to_euler_defines.svh"

module rotation_matrix_to_euler #(
  parameter int ENTRY_WIDTH = rme_pkg::ENTRY_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire signed [ENTRY_WIDTH-1:0]       in_r00,
  input  wire signed [ENTRY_WIDTH-1:0]       in_r10,
  input  wire signed [ENTRY_WIDTH-1:0]       in_r20,
  input  wire signed [ENTRY_WIDTH-1:0]       in_r21,
  input  wire signed [ENTRY_WIDTH-1:0]       in_r22,
  input  wire signed [ENTRY_WIDTH-1:0]       in_r11,
  input  wire signed [ENTRY_WIDTH-1:0]       in_r12,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [rme_pkg::THR_W-1:0]           cfg_singular_threshold,
  output logic                               out_valid,
  output logic signed [rme_pkg::OUT_W-1:0]   out_angle_x,
  output logic signed [rme_pkg::OUT_W-1:0]   out_angle_y,
  output logic signed [rme_pkg::OUT_W-1:0]   out_angle_z,
  output logic                               out_singular
);

  localparam int W     = ENTRY_WIDTH;
  localparam int SW    = 2 * W;
  localparam int LW    = W + 2;
  localparam int CW    = W + 28;
  localparam int TW    = (W > rme_pkg::THR_W) ? W : rme_pkg::THR_W;
  localparam int NI    = rme_pkg::CORDIC_ITERS;
  localparam int AW    = rme_pkg::ANG_W;
  localparam int LAT   = W + 35;
  localparam logic signed [AW-1:0] RND = AW'(32768);
  localparam logic signed [AW-1:0] OMAX = AW'(rme_pkg::OUT_MAX);

  // entry slots in the packed carry word
  localparam int E00 = 0;
  localparam int E10 = 1;
  localparam int E20 = 2;
  localparam int E21 = 3;
  localparam int E22 = 4;
  localparam int E11 = 5;
  localparam int E12 = 6;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // threshold register
  logic [rme_pkg::THR_W-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rme_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_singular_threshold;
    end
  end

  // input register
  logic [7*W-1:0] ent_in_r;
  logic           vin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_r <= 1'b0;
    end else begin
      vin_r <= start && !busy;
    end
  end
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ent_in_r <= {in_r12, in_r11, in_r22, in_r21, in_r20, in_r10, in_r00};
    end
  end

  // squares of the column 0 magnitudes
  logic signed [W-1:0] e00_in, e10_in;
  logic [W-1:0]        a00, a10;
  logic [SW-1:0]       sq0_r, sq1_r;
  logic [7*W-1:0]      ent_sq_r;
  logic                vsq_r;
  assign e00_in = ent_in_r[E00*W +: W];
  assign e10_in = ent_in_r[E10*W +: W];
  assign a00 = e00_in[W-1] ? W'(-e00_in) : W'(e00_in);
  assign a10 = e10_in[W-1] ? W'(-e10_in) : W'(e10_in);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsq_r <= 1'b0;
    end else begin
      vsq_r <= vin_r;
    end
  end
  always_ff @(posedge clk) begin
    sq0_r    <= SW'(a00) * SW'(a00);
    sq1_r    <= SW'(a10) * SW'(a10);
    ent_sq_r <= ent_in_r;
  end

  // square root, one result bit per stage
  logic [SW-1:0]  rem_r [0:W];
  logic [W-1:0]   res_r [0:W];
  logic [7*W-1:0] ent_s_r [0:W];
  logic           vs_r [0:W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else begin
      vs_r[0] <= vsq_r;
    end
  end
  always_ff @(posedge clk) begin
    rem_r[0]   <= sq0_r + sq1_r;
    res_r[0]   <= '0;
    ent_s_r[0] <= ent_sq_r;
  end

  for (genvar j = 1; j <= W; j++) begin : g_sqrt
    localparam int B = W - j;
    logic [SW-1:0] trial;
    assign trial = (SW'(res_r[j-1]) << (B + 1)) | (SW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[j] <= 1'b0;
      end else begin
        vs_r[j] <= vs_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      ent_s_r[j] <= ent_s_r[j-1];
      if (rem_r[j-1] >= trial) begin
        rem_r[j] <= rem_r[j-1] - trial;
        res_r[j] <= res_r[j-1] | (W'(1) << B);
      end else begin
        rem_r[j] <= rem_r[j-1];
        res_r[j] <= res_r[j-1];
      end
    end
  end

  // singular decision and lane operands: lane 0 is x, 1 is y, 2 is z
  logic [W-1:0]        s_val;
  logic                sing;
  logic signed [W-1:0] p00, p10, p20, p21, p22, p11, p12;
  logic signed [LW-1:0] ly [0:2];
  logic signed [LW-1:0] lx [0:2];

  assign s_val = res_r[W];
  assign sing  = TW'(s_val) < TW'(thr_r);
  assign p00 = ent_s_r[W][E00*W +: W];
  assign p10 = ent_s_r[W][E10*W +: W];
  assign p20 = ent_s_r[W][E20*W +: W];
  assign p21 = ent_s_r[W][E21*W +: W];
  assign p22 = ent_s_r[W][E22*W +: W];
  assign p11 = ent_s_r[W][E11*W +: W];
  assign p12 = ent_s_r[W][E12*W +: W];
  assign ly[0] = sing ? -LW'(p12) : LW'(p21);
  assign lx[0] = sing ? LW'(p11) : LW'(p22);
  assign ly[1] = -LW'(p20);
  assign lx[1] = $signed({2'b00, s_val});
  assign ly[2] = LW'(p10);
  assign lx[2] = LW'(p00);

  // cordic pipeline storage
  logic signed [CW-1:0] cx_r [0:2][0:NI];
  logic signed [CW-1:0] cy_r [0:2][0:NI];
  logic signed [AW-1:0] cz_r [0:2][0:NI];
  logic                 zy_r [0:2][0:NI];
  logic                 xn_r [0:2][0:NI];
  logic                 sg_r [0:NI];
  logic                 vc_r [0:NI];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r[0] <= 1'b0;
    end else begin
      vc_r[0] <= vs_r[W];
    end
  end
  always_ff @(posedge clk) begin
    sg_r[0] <= sing;
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic                 yzero, xneg;
    logic signed [LW-1:0] xp, yp;
    logic signed [AW-1:0] base;

    // fold the left half plane onto the right one
    assign yzero = (ly[l] == '0);
    assign xneg  = lx[l][LW-1];
    assign xp    = xneg ? -lx[l] : lx[l];
    assign yp    = xneg ? -ly[l] : ly[l];
    assign base  = !xneg ? '0 : (ly[l][LW-1] ? -rme_pkg::PI_Q29 : rme_pkg::PI_Q29);

    always_ff @(posedge clk) begin
      cx_r[l][0] <= CW'(xp) <<< rme_pkg::PRESCALE_SH;
      cy_r[l][0] <= CW'(yp) <<< rme_pkg::PRESCALE_SH;
      cz_r[l][0] <= base;
      zy_r[l][0] <= yzero;
      xn_r[l][0] <= xneg;
    end

    // vectoring iterations, one per stage
    for (genvar i = 0; i < NI; i++) begin : g_iter
      localparam logic signed [AW-1:0] ANG = rme_pkg::atan_q29(i);
      logic signed [CW-1:0] xs, ys;
      assign xs = cx_r[l][i] >>> i;
      assign ys = cy_r[l][i] >>> i;
      always_ff @(posedge clk) begin
        zy_r[l][i+1] <= zy_r[l][i];
        xn_r[l][i+1] <= xn_r[l][i];
        if (!cy_r[l][i][CW-1]) begin
          cx_r[l][i+1] <= cx_r[l][i] + ys;
          cy_r[l][i+1] <= cy_r[l][i] - xs;
          cz_r[l][i+1] <= cz_r[l][i] + ANG;
        end else begin
          cx_r[l][i+1] <= cx_r[l][i] - ys;
          cy_r[l][i+1] <= cy_r[l][i] + xs;
          cz_r[l][i+1] <= cz_r[l][i] - ANG;
        end
      end
    end
  end

  // stage valid and singular flag alongside the iterations
  for (genvar i = 0; i < NI; i++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vc_r[i+1] <= 1'b0;
      end else begin
        vc_r[i+1] <= vc_r[i];
      end
    end
    always_ff @(posedge clk) begin
      sg_r[i+1] <= sg_r[i];
    end
  end

  // round to q3.13 and clamp
  logic signed [AW-1:0]    rnd [0:2];
  logic signed [rme_pkg::OUT_W-1:0] ang [0:2];
  for (genvar l = 0; l < 3; l++) begin : g_round
    assign rnd[l] = (cz_r[l][NI] + RND) >>> 16;
    always_comb begin
      if (zy_r[l][NI]) begin
        ang[l] = xn_r[l][NI] ? rme_pkg::OUT_W'(rme_pkg::OUT_MAX) : '0;
      end else if (rnd[l] > OMAX) begin
        ang[l] = rme_pkg::OUT_W'(rme_pkg::OUT_MAX);
      end else if (rnd[l] < -OMAX) begin
        ang[l] = -rme_pkg::OUT_W'(rme_pkg::OUT_MAX);
      end else begin
        ang[l] = rnd[l][rme_pkg::OUT_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vc_r[NI];
    end
  end
  always_ff @(posedge clk) begin
    out_angle_x  <= ang[0];
    out_angle_y  <= ang[1];
    out_angle_z  <= sg_r[NI] ? '0 : ang[2];
    out_singular <= sg_r[NI];
  end

  // checks
  `RME_ASSERT_IMP(a_latency, start && !busy, ##LAT out_valid, "result missing after latency")
  `RME_ASSERT_IMP(a_sing_z, out_valid && out_singular, out_angle_z == '0, "z not zero when singular")
  `RME_ASSERT_IMP(a_range, out_valid, (out_angle_y <= 16'sd25736) && (out_angle_y >= -16'sd25736), "y out of range")
  `RME_ASSERT_ALWAYS(a_no_busy, !busy, "busy raised")

endmodule

`default_nettype wire

>>> test/rotation_matrix_to_euler_tb.sv
// self-checking testbench for the rotation matrix to euler angle block
// predicts angles with a fixed-point cordic model; depends on rme_pkg and the dut
`timescale 1ns / 1ps

module rotation_matrix_to_euler_tb;

  localparam int EW        = rme_pkg::ENTRY_WIDTH_DEF;
  localparam int OW        = rme_pkg::OUT_W;
  localparam int TWD       = rme_pkg::THR_W;
  localparam int LATENCY   = EW + 35;
  localparam int N_RANDOM  = 1400;

  typedef logic signed [EW-1:0] entry_t;

  typedef struct packed {
    entry_t r00, r10, r20, r21, r22, r11, r12;
  } matrix_t;

  typedef struct packed {
    logic signed [OW-1:0] ax, ay, az;
    logic                 sing;
  } euler_t;

  logic clk, rst_n;
  logic start, busy;
  entry_t in_r00, in_r10, in_r20, in_r21, in_r22, in_r11, in_r12;
  logic cfg_valid, cfg_ready;
  logic [TWD-1:0] cfg_singular_threshold;
  logic out_valid, out_singular;
  logic signed [OW-1:0] out_angle_x, out_angle_y, out_angle_z;

  rotation_matrix_to_euler u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_r00(in_r00), .in_r10(in_r10), .in_r20(in_r20), .in_r21(in_r21),
    .in_r22(in_r22), .in_r11(in_r11), .in_r12(in_r12),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_singular_threshold(cfg_singular_threshold),
    .out_valid(out_valid), .out_angle_x(out_angle_x), .out_angle_y(out_angle_y),
    .out_angle_z(out_angle_z), .out_singular(out_singular)
  );

  // clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  matrix_t      pending_mats[$];
  euler_t       expected_angles[$];
  logic [TWD-1:0] threshold_q;
  int           send_idle_pct;
  int           mismatches, results_seen, singular_seen;

  // append a matrix to the driver queue
  function automatic void queue_matrix(matrix_t m);
    pending_mats = {pending_mats, m};
  endfunction

  // cordic atan2 with rounding to q3.13 and clamping
  function automatic logic signed [OW-1:0] cordic_atan2(longint yv, longint xv);
    longint base, x, y, z, xs, ys, r, ang;
    base = 0;
    if (yv == 0) return (xv >= 0) ? 16'sd0 : OW'(rme_pkg::OUT_MAX);
    if (xv < 0) begin
      base = (yv > 0) ? longint'(rme_pkg::PI_Q29) : -longint'(rme_pkg::PI_Q29);
      xv = -xv;
      yv = -yv;
    end
    x = xv <<< rme_pkg::PRESCALE_SH;
    y = yv <<< rme_pkg::PRESCALE_SH;
    z = 0;
    for (int i = 0; i < rme_pkg::CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      ang = (i < 10) ? longint'(rme_pkg::atan_q29(i))
                     : (longint'(1) <<< (rme_pkg::ANG_FRAC - i));
      if (y >= 0) begin
        x += ys; y -= xs; z += ang;
      end else begin
        x -= ys; y += xs; z -= ang;
      end
    end
    r = (base + z + 32768) >>> 16;
    if (r > rme_pkg::OUT_MAX) r = rme_pkg::OUT_MAX;
    if (r < -rme_pkg::OUT_MAX) r = -rme_pkg::OUT_MAX;
    return OW'(r);
  endfunction

  // floor square root of a non-negative integer
  function automatic longint floor_sqrt(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = longint'(1) <<< 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic euler_t predict_euler(matrix_t m, logic [TWD-1:0] thr);
    euler_t e;
    longint s;
    s = floor_sqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
    e.sing = (s < longint'(thr));
    e.ay = cordic_atan2(-longint'(m.r20), s);
    if (!e.sing) begin
      e.ax = cordic_atan2(m.r21, m.r22);
      e.az = cordic_atan2(m.r10, m.r00);
    end else begin
      e.ax = cordic_atan2(-longint'(m.r12), m.r11);
      e.az = '0;
    end
    return e;
  endfunction

  // driver: one matrix per transfer, random idle gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (pending_mats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        matrix_t m;
        m = pending_mats.pop_front();
        {in_r00, in_r10, in_r20, in_r21, in_r22, in_r11, in_r12} <= m;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // predictor on each accepted matrix transfer
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      expected_angles = {expected_angles, predict_euler(
        {in_r00, in_r10, in_r20, in_r21, in_r22, in_r11, in_r12}, threshold_q)};
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      euler_t e;
      results_seen++;
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = expected_angles.pop_front();
        if (out_singular) singular_seen++;
        if (out_angle_x !== e.ax || out_angle_y !== e.ay || out_angle_z !== e.az ||
            out_singular !== e.sing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp x=%0d y=%0d z=%0d s=%0b got x=%0d y=%0d z=%0d s=%0b",
                     $realtime, e.ax, e.ay, e.az, e.sing,
                     out_angle_x, out_angle_y, out_angle_z, out_singular);
        end
      end
    end
  end

  function automatic entry_t rand_entry();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return entry_t'($urandom);
    if (pick == 1) return entry_t'($urandom_range(32) - 16);
    return entry_t'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m.r00 = rand_entry(); m.r10 = rand_entry(); m.r20 = rand_entry();
    m.r21 = rand_entry(); m.r22 = rand_entry(); m.r11 = rand_entry();
    m.r12 = rand_entry();
    // near gimbal lock: first column mostly along z
    if ($urandom_range(3) == 0) begin
      m.r00 = entry_t'(int'($urandom_range(400)) - 200);
      m.r10 = entry_t'(int'($urandom_range(400)) - 200);
    end
    return m;
  endfunction

  task automatic write_threshold(logic [TWD-1:0] thr);
    @(negedge clk);
    cfg_singular_threshold <= thr;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    threshold_q = thr;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_mats.size() > 0 || start || expected_angles.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_phase(int n, int idle_pct);
    send_idle_pct = idle_pct;
    repeat (n) queue_matrix(rand_matrix());
    drain();
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0;
    cfg_singular_threshold = '0; threshold_q = rme_pkg::THR_RESET;
    {in_r00, in_r10, in_r20, in_r21, in_r22, in_r11, in_r12} = '0;
    mismatches = 0; results_seen = 0; singular_seen = 0; send_idle_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zeros, identity, extremes, gimbal lock, out-of-range entries
    queue_matrix('0);
    queue_matrix('{16384, 0, 0, 0, 16384, 16384, 0});
    queue_matrix('{-16384, 0, 0, 0, -16384, -16384, 0});
    queue_matrix('{0, 16384, 0, 0, 16384, 0, -16384});
    queue_matrix('{0, -16384, 0, 16384, 0, 0, 16384});
    queue_matrix('{0, 0, -16384, 0, 0, 16384, 0});
    queue_matrix('{0, 0, 16384, 0, 0, -16384, 16384});
    queue_matrix('{0, 0, 16384, 0, 0, 0, 0});
    queue_matrix('{-16384, 0, 0, 0, -1, 0, 0});
    queue_matrix('{-1, 0, 0, 1, -1, 0, 0});
    queue_matrix('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                   16'sh7fff, 16'sh7fff, 16'sh7fff});
    queue_matrix('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                   16'sh8000, 16'sh8000, 16'sh8000});
    queue_matrix('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                   16'sh8000, 16'sh7fff, 16'sh8000});
    queue_matrix('{11585, 11585, 0, 11585, 11585, 11585, -11585});
    queue_matrix('{1, 0, 16383, 5, 7, -3, 2});
    drain();

    // thresholds: zero, maximum, in between, with idling phases
    write_threshold('0);
    queue_matrix('0);
    random_phase(300, 0);
    write_threshold(15'd16384);
    random_phase(200, 61);
    write_threshold(15'd200);
    random_phase(350, 31);
    write_threshold(15'h7fff);
    random_phase(200, 0);
    write_threshold(15'd50);
    random_phase(350, 61);

    $display("covered %0d result transfers, %0d in gimbal lock, thresholds 0 to max",
             results_seen, singular_seen);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("rotation_matrix_to_euler_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_angles.size());
      $display("rotation_matrix_to_euler_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout");
    $display("rotation_matrix_to_euler_tb: FAIL");
    $finish;
  end

endmodule
